// ===== sv/nnfs_pkg.sv =====
// ----------------------------------------------------------------------------
// nnfs_pkg: shared types and constants of the nearest-neighbor frame scaler
// Output frame geometry, field widths, register indexes, the controller's
// state type and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package nnfs_pkg;

   // Output frame
   localparam int OutWidth  = 64;
   localparam int OutHeight = 32;
   localparam int MaxLine   = 1024;

   // Field widths
   localparam int PixelW  = 16;
   localparam int ColW    = 6;   // output column
   localparam int RowW    = 5;   // output row
   localparam int WidthW  = 11;  // source_width register
   localparam int HeightW = 13;  // source_height register
   localparam int SrcColW = 10;  // source column counter
   localparam int SrcRowW = 12;  // source row counter
   localparam int ProdW   = ColW + WidthW;

   // Row range divider: quotient bits, one per step
   localparam int DivSteps = RowW;
   localparam int StepCntW = 3;

   // Configuration register indexes
   localparam int CsrIdxW = 1;
   localparam logic [CsrIdxW-1:0] CsrSourceWidth  = 1'b0;
   localparam logic [CsrIdxW-1:0] CsrSourceHeight = 1'b1;
   localparam int CsrDataW = HeightW;

   // Reset values of the registers
   localparam logic [WidthW-1:0]  ResetWidth  = 11'd64;
   localparam logic [HeightW-1:0] ResetHeight = 13'd32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_INIT,
      ST_DIV,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic load;      // take the input word, apply frame start / new line
      logic div_init;  // seed the row range divider
      logic div_step;  // one quotient bit
      logic advance;   // move to the next output column
      logic emit;      // write a result into the output register
      logic finish;    // bump the source column, maybe start a new line
   } cmd_type;

   typedef struct packed {
      logic width_ok;  // source_width in 1..MaxLine
      logic skip;      // current output column maps before this pixel
      logic match;     // current output column maps onto this pixel
      logic visible;   // source row lands inside the output frame
      logic out_free;  // output register can take a word this cycle
   } status_type;

endpackage

// ===== sv/nnfs_csr.sv =====
// ----------------------------------------------------------------------------
// nnfs_csr: configuration registers
// Holds source_width and source_height, writes by index, and derives the
// width check and the effective height (zero taken as one).
// ----------------------------------------------------------------------------
module nnfs_csr
   import nnfs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_data,
   output logic [WidthW-1:0]   src_width,
   output logic [HeightW-1:0]  src_height,
   output logic                width_ok
);

   logic [WidthW-1:0]  width_ff, width_in;
   logic [HeightW-1:0] height_ff, height_in;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         case (csr_index)
            CsrSourceWidth:  width_in  = csr_data[WidthW-1:0];
            CsrSourceHeight: height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ResetWidth;
         height_ff <= ResetHeight;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign src_width  = width_ff;
   assign src_height = (height_ff == '0) ? HeightW'(1) : height_ff;
   assign width_ok   = (width_ff != '0) && (width_ff <= WidthW'(MaxLine));

endmodule

// ===== sv/nnfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// nnfs_ctrl: sequencing controller
// Takes one pixel and, when source_width is valid, runs the row range division,
// then walks output columns one per cycle, emitting results and stalling while the output register is full.
// ----------------------------------------------------------------------------
module nnfs_ctrl
   import nnfs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type            state_ff, state_in;
   logic [StepCntW-1:0]  step_ff, step_in;
   logic                 div_done;

   assign div_done = (step_ff == StepCntW'(DivSteps - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && status.width_ok) begin
               state_in = ST_DIV_INIT;
            end
         end
         ST_DIV_INIT: begin
            state_in = ST_DIV;
            step_in  = '0;
         end
         ST_DIV: begin
            step_in = step_ff + 1'b1;
            if (div_done) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!status.skip && !status.match) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_DIV_INIT: cmd.div_init = 1'b1;
         ST_DIV:      cmd.div_step = 1'b1;
         ST_SCAN: begin
            if (status.skip) begin
               cmd.advance = 1'b1;
            end else if (status.match) begin
               if (!status.visible) begin
                  cmd.advance = 1'b1;
               end else if (status.out_free) begin
                  cmd.advance = 1'b1;
                  cmd.emit    = 1'b1;
               end
            end else begin
               cmd.finish = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== sv/nnfs_datapath.sv =====
// ----------------------------------------------------------------------------
// nnfs_datapath: counters, row range divider, column mapper, output register
// Two restoring dividers give floor(row*32/h) and floor((row+1)*32/h); one
// 6x11 multiply per cycle maps the current output column to its source column.
// ----------------------------------------------------------------------------
module nnfs_datapath
   import nnfs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic                width_ok,
   input  logic [WidthW-1:0]   src_width,
   input  logic [HeightW-1:0]  src_height,
   input  logic [PixelW-1:0]   req_tdata,
   input  logic                req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,
   output logic                rsp_tlast
);

   // source position
   logic [SrcColW-1:0] col_ff, col_in;
   logic [SrcRowW-1:0] row_ff, row_in;
   logic [ColW:0]      nxt_ff, nxt_in;
   logic [PixelW-1:0]  pixel_ff;

   // row range divider
   logic [HeightW-1:0] rem0_ff, rem0_in, rem1_ff, rem1_in;
   logic [RowW-1:0]    quo0_ff, quo0_in, quo1_ff, quo1_in;
   logic               inv0_ff, inv0_in, inv1_ff, inv1_in;

   // output register
   logic               out_valid_ff, out_valid_in;
   logic [ColW-1:0]    out_col_ff;
   logic [RowW-1:0]    out_first_ff, out_last_ff;
   logic [PixelW-1:0]  out_sample_ff;
   logic               out_tlast_ff;

   // scan logic
   logic               in_range;
   logic [ProdW-1:0]   prod, prod_next;
   logic [WidthW-1:0]  col_ext;
   logic               final_col;
   logic [RowW:0]      y1_raw, y1;
   logic [RowW-1:0]    row_last;

   // frame start / new line on load
   logic [SrcColW-1:0] col_a;
   logic [SrcRowW-1:0] row_a;
   logic [ColW:0]      nxt_a;
   logic [SrcColW-1:0] col_p;

   function automatic logic [HeightW:0] div_step(input logic [HeightW-1:0] rem,
                                                 input logic [HeightW-1:0] den);
      logic [HeightW:0] t;
      logic [HeightW:0] d;
      d = {1'b0, den};
      t = {rem, 1'b0};
      if (t >= d) begin
         div_step = {t - d};
         div_step = {div_step[HeightW-1:0], 1'b1};
      end else begin
         div_step = {t[HeightW-1:0], 1'b0};
      end
   endfunction

   // column mapping: source column of output column nxt is (nxt*w)/64
   assign in_range  = !nxt_ff[ColW];
   assign prod      = ProdW'(nxt_ff[ColW-1:0]) * ProdW'(src_width);
   assign prod_next = prod + ProdW'(src_width);
   assign col_ext   = {1'b0, col_ff};
   assign final_col = (nxt_ff[ColW-1:0] == ColW'(OutWidth - 1)) ||
                      (prod_next[ProdW-1:ColW] != col_ext);

   // last output row: at least one row, clipped to the frame
   assign y1_raw   = inv1_ff ? (RowW+1)'(OutHeight) : {1'b0, quo1_ff};
   assign y1       = (y1_raw <= {1'b0, quo0_ff}) ? ({1'b0, quo0_ff} + 1'b1) : y1_raw;
   assign row_last = RowW'(y1 - 1'b1);

   assign status.width_ok = width_ok;
   assign status.skip     = in_range && (prod[ProdW-1:ColW] < col_ext);
   assign status.match    = in_range && (prod[ProdW-1:ColW] == col_ext);
   assign status.visible  = !inv0_ff;
   assign status.out_free = !out_valid_ff || rsp_tready;

   assign col_a = req_tuser ? '0 : col_ff;
   assign row_a = req_tuser ? '0 : row_ff;
   assign nxt_a = req_tuser ? '0 : nxt_ff;
   assign col_p = col_ff + 1'b1;

   always_comb begin
      logic [HeightW:0] s0, s1;
      col_in  = col_ff;
      row_in  = row_ff;
      nxt_in  = nxt_ff;
      rem0_in = rem0_ff;
      rem1_in = rem1_ff;
      quo0_in = quo0_ff;
      quo1_in = quo1_ff;
      inv0_in = inv0_ff;
      inv1_in = inv1_ff;
      s0 = div_step(rem0_ff, src_height);
      s1 = div_step(rem1_ff, src_height);
      if (cmd.load) begin
         col_in = col_a;
         row_in = row_a;
         nxt_in = nxt_a;
         // width shrunk mid-line: open a new line first
         if (width_ok && ({1'b0, col_a} >= src_width)) begin
            col_in = '0;
            nxt_in = '0;
            row_in = row_a + 1'b1;
         end
      end
      if (cmd.div_init) begin
         rem0_in = HeightW'(row_ff);
         rem1_in = HeightW'(row_ff) + 1'b1;
         quo0_in = '0;
         quo1_in = '0;
         inv0_in = (HeightW'(row_ff) >= src_height);
         inv1_in = ((HeightW'(row_ff) + 1'b1) >= src_height);
      end
      if (cmd.div_step) begin
         rem0_in = s0[HeightW:1];
         rem1_in = s1[HeightW:1];
         quo0_in = {quo0_ff[RowW-2:0], s0[0]};
         quo1_in = {quo1_ff[RowW-2:0], s1[0]};
      end
      if (cmd.advance) begin
         nxt_in = nxt_ff + 1'b1;
      end
      if (cmd.finish) begin
         if ((col_p == '0) || ({1'b0, col_p} >= src_width)) begin
            col_in = '0;
            nxt_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_p;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         nxt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         nxt_ff       <= nxt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem0_ff <= rem0_in;
      rem1_ff <= rem1_in;
      quo0_ff <= quo0_in;
      quo1_ff <= quo1_in;
      inv0_ff <= inv0_in;
      inv1_ff <= inv1_in;
      if (cmd.load) begin
         pixel_ff <= req_tdata;
      end
      if (cmd.emit) begin
         out_col_ff    <= nxt_ff[ColW-1:0];
         out_first_ff  <= quo0_ff;
         out_last_ff   <= row_last;
         out_sample_ff <= pixel_ff;
         out_tlast_ff  <= final_col;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_sample_ff, out_last_ff, out_first_ff, out_col_ff};
   assign rsp_tlast  = out_tlast_ff;

endmodule

// ===== sv/nearest_neighbor_frame_scaler.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbor_frame_scaler: RGB565 stream to 64x32 nearest-neighbor frame
// Per pixel: load, divider seed, the 5-step row range divider, then a column scan
// that skips or emits one output column per cycle (at most 64 columns over a line),
// stalling on a match while the output register is full. Results leave through the
// output register. Pixels taken while source_width is bad are dropped.
// Reset: counters cleared, source_width 64, source_height 32, no clearing pass.
// ----------------------------------------------------------------------------
module nearest_neighbor_frame_scaler
   import nnfs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // pixel input
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,   // [15:0] pixel
   input  logic                req_tuser,   // [0] frame_start
   // result output
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,   // [5:0] column, [10:6] row_first,
                                            // [15:11] row_last, [31:16] sample
   output logic                rsp_tlast,   // last result of this pixel
   // configuration writes
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,   // 0 source_width, 1 source_height
   input  logic [CsrDataW-1:0] csr_data
);

   logic [WidthW-1:0]  src_width;
   logic [HeightW-1:0] src_height;   // zero already mapped to one
   logic               width_ok;
   cmd_type            cmd;
   status_type         status;

   // Register file; writes are only expected while the block is idle.
   nnfs_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .src_width  (src_width),
      .src_height (src_height),
      .width_ok   (width_ok)
   );

   // Sequencer: load -> divider seed -> 5 divide steps -> column scan.
   nnfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Counters, divider, column mapper and the output register. The output
   // register decouples the sides: a new pixel word is taken while a result
   // still waits for rsp_tready.
   nnfs_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .width_ok   (width_ok),
      .src_width  (src_width),
      .src_height (src_height),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
